FILE: rtl/tat_pkg.sv
// ----------------------------------------------------------------------------
// tat_pkg
// shared types, constants and the output clamp for the trilateration solver
// ----------------------------------------------------------------------------
`default_nettype none

package tat_pkg;

   // result coordinate width, signed fixed point
   localparam int OUT_W = 26;

   localparam logic [OUT_W-1:0] OUT_POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR0_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR0_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR1_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR1_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR2_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR2_Y = 3'd5;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_COLLINEAR = 2'd1,
      ST_SHARED_X  = 2'd2
   } status_type;

   typedef struct packed {
      logic             clip;
      logic [OUT_W-1:0] val;
   } sat_type;

   // sign-magnitude quotient to clamped two's complement
   function automatic sat_type saturate(logic neg, logic [OUT_W-1:0] quo, logic ovf);
      sat_type          r;
      logic [OUT_W-1:0] lim;
      logic [OUT_W-1:0] mag;
      lim    = neg ? OUT_NEG_LIM : OUT_POS_LIM;
      r.clip = ovf || (quo > lim);
      mag    = r.clip ? lim : quo;
      r.val  = neg ? (~mag + 1'b1) : mag;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/three_anchor_trilateration.sv
// ----------------------------------------------------------------------------
// three_anchor_trilateration
// 2-d position from three ranges to three configured anchors
// ----------------------------------------------------------------------------
// Fully pipelined solver: one range triple may enter every clock while
// req_stall is low, and one result leaves per item, in order. Each of the
// two restoring dividers spends one stage per quotient bit plus an entry
// stage. Anchor-only terms (squared norms, coordinate differences,
// determinant) are rebuilt from the anchor registers after a write, through
// registered squares, norms and products, determinant, then its magnitude.
// The whole pipeline holds in place while a result sits unaccepted at the
// output; req_stall follows it. pos_x and pos_y are signed with FRAC_BITS
// fractional bits, rounded to nearest with ties away from zero and clamped
// to 26 bits. Status reports collinear anchors (all coordinates 0) or
// anchors 0 and 1 sharing x (pos_x 0).
// ----------------------------------------------------------------------------
`default_nettype none

module three_anchor_trilateration #(
   parameter int FRAC_BITS  = 8,
   parameter int COORD_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // range triple
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [COORD_BITS:0]               req_range0,
   input  wire logic [COORD_BITS:0]               req_range1,
   input  wire logic [COORD_BITS:0]               req_range2,
   // position result
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [tat_pkg::OUT_W-1:0]       rsp_pos_x,
   output logic signed [tat_pkg::OUT_W-1:0]       rsp_pos_y,
   output tat_pkg::status_type                    rsp_status,
   output logic                                   rsp_clipped,
   // anchor registers
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tat_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [COORD_BITS-1:0]             csr_data
);

   import tat_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int F    = FRAC_BITS;
   localparam int RW   = CW + 1;          // range
   localparam int SQW  = 2 * RW;          // range squared
   localparam int DW   = 2 * CW + 1;      // anchor squared norm
   localparam int TW   = 2 * CW + 4;      // t2, s2 (signed)
   localparam int XDW  = CW + 1;          // coordinate difference (signed)
   localparam int DETW = 2 * CW + 2;      // determinant (signed)
   localparam int PW   = TW + XDW;        // t2 * dx (signed)
   localparam int NUMW = PW + 1;          // y numerator (signed)
   localparam int NYW  = NUMW + F + 2;    // y dividend
   localparam int QW   = OUT_W + XDW;     // pos_y * dy01 (signed)
   localparam int NXA  = (QW + 1 > TW + F) ? QW + 1 : TW + F;
   localparam int NXW  = NXA + 1;         // x numerator (signed)
   localparam int NX2W = NXW + 2;         // x dividend
   localparam int SYW  = TW + 1;          // y divider side data
   localparam int SXW  = OUT_W + 2;       // x divider side data

   // global advance: hold everything while the output waits
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------------------------
   // anchor registers
   // ------------------------------------------------------------------------
   logic [CW-1:0] ax0_ff, ay0_ff, ax1_ff, ay1_ff, ax2_ff, ay2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax0_ff <= '0;
         ay0_ff <= '0;
         ax1_ff <= '0;
         ay1_ff <= '0;
         ax2_ff <= '0;
         ay2_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ANCHOR0_X: ax0_ff <= csr_data;
            CSR_ANCHOR0_Y: ay0_ff <= csr_data;
            CSR_ANCHOR1_X: ax1_ff <= csr_data;
            CSR_ANCHOR1_Y: ay1_ff <= csr_data;
            CSR_ANCHOR2_X: ax2_ff <= csr_data;
            CSR_ANCHOR2_Y: ay2_ff <= csr_data;
            default: ;     // writes beyond the list are dropped
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // anchor-only terms, rebuilt continuously from the registers
   // ------------------------------------------------------------------------
   logic [2*CW-1:0]        sx0_ff, sy0_ff, sx1_ff, sy1_ff, sx2_ff, sy2_ff;
   logic signed [XDW-1:0]  dx10_ff, dx12_ff, dy01_ff, dy21_ff;
   logic [DW-1:0]          dd0_ff, dd1_ff, dd2_ff;
   logic signed [DETW-1:0] dpa_ff, dpb_ff, det_ff;
   logic [DETW-1:0]        detmag_ff;
   logic                   detneg_ff;
   logic [XDW-1:0]         dxmag_ff;
   logic                   dxneg_ff;

   always_ff @(posedge clock) begin
      // squares and differences
      sx0_ff  <= ax0_ff * ax0_ff;
      sy0_ff  <= ay0_ff * ay0_ff;
      sx1_ff  <= ax1_ff * ax1_ff;
      sy1_ff  <= ay1_ff * ay1_ff;
      sx2_ff  <= ax2_ff * ax2_ff;
      sy2_ff  <= ay2_ff * ay2_ff;
      dx10_ff <= $signed({1'b0, ax1_ff}) - $signed({1'b0, ax0_ff});
      dx12_ff <= $signed({1'b0, ax1_ff}) - $signed({1'b0, ax2_ff});
      dy01_ff <= $signed({1'b0, ay0_ff}) - $signed({1'b0, ay1_ff});
      dy21_ff <= $signed({1'b0, ay2_ff}) - $signed({1'b0, ay1_ff});
      // squared norms and determinant products
      dd0_ff  <= DW'(sx0_ff) + DW'(sy0_ff);
      dd1_ff  <= DW'(sx1_ff) + DW'(sy1_ff);
      dd2_ff  <= DW'(sx2_ff) + DW'(sy2_ff);
      dpa_ff  <= dx12_ff * dy01_ff;
      dpb_ff  <= dy21_ff * dx10_ff;
      dxneg_ff <= dx10_ff[XDW-1];
      dxmag_ff <= dx10_ff[XDW-1] ? XDW'(-dx10_ff) : XDW'(dx10_ff);
      // determinant, then its magnitude
      det_ff    <= dpa_ff - dpb_ff;
      detneg_ff <= det_ff[DETW-1];
      detmag_ff <= det_ff[DETW-1] ? DETW'(-det_ff) : DETW'(det_ff);
   end

   logic det_zero, dx_zero;
   assign det_zero = (detmag_ff == '0);
   assign dx_zero  = (dxmag_ff == '0);

   // ------------------------------------------------------------------------
   // front end: squares, t2 / s2, y numerator
   // ------------------------------------------------------------------------
   logic                  v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic [RW-1:0]         r0_ff, r1_ff, r2_ff;
   logic [SQW-1:0]        q0_ff, q1_ff, q2_ff;
   logic signed [TW-1:0]  t2_ff, s2_ff, t2_4_ff, t2_5_ff, t2_6_ff;
   logic signed [PW-1:0]  pa_ff, pb_ff;
   logic signed [NUMW-1:0] num_ff;
   logic [NUMW-1:0]       nmag_ff;
   logic                  nneg_ff;

   logic signed [TW-1:0]  t2_in, s2_in;
   logic signed [NUMW-1:0] num_in;

   always_comb begin
      t2_in = $signed(TW'(dd0_ff)) - $signed(TW'(dd1_ff))
            + $signed(TW'(q1_ff)) - $signed(TW'(q0_ff));
      s2_in = $signed(TW'(dd2_ff)) - $signed(TW'(dd1_ff))
            + $signed(TW'(q1_ff)) - $signed(TW'(q2_ff));
      num_in = NUMW'(pa_ff) - NUMW'(pb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r0_ff   <= req_range0;
         r1_ff   <= req_range1;
         r2_ff   <= req_range2;
         q0_ff   <= r0_ff * r0_ff;
         q1_ff   <= r1_ff * r1_ff;
         q2_ff   <= r2_ff * r2_ff;
         t2_ff   <= t2_in;
         s2_ff   <= s2_in;
         pa_ff   <= t2_ff * dx12_ff;
         pb_ff   <= s2_ff * dx10_ff;
         t2_4_ff <= t2_ff;
         num_ff  <= num_in;
         t2_5_ff <= t2_4_ff;
         nneg_ff <= num_ff[NUMW-1];
         nmag_ff <= num_ff[NUMW-1] ? NUMW'(-num_ff) : NUMW'(num_ff);
         t2_6_ff <= t2_5_ff;
      end
   end

   // ------------------------------------------------------------------------
   // y divider: round(num * 2^F / (2 det)) as (2n + 2|det|) / (4|det|)
   // ------------------------------------------------------------------------
   logic [NYW-1:0] ny_num, ny_den;
   logic [SYW-1:0] ny_side, yq_side;
   logic           yq_valid, yq_ovf;
   logic [OUT_W-1:0] yq_quo;

   assign ny_num  = (NYW'(nmag_ff) << (F + 1)) + (NYW'(detmag_ff) << 1);
   assign ny_den  = NYW'(detmag_ff) << 2;
   assign ny_side = {nneg_ff ^ detneg_ff, t2_6_ff};

   tat_div #(
      .NW (NYW),
      .QB (OUT_W),
      .SW (SYW)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v6_ff),
      .in_num    (ny_num),
      .in_den    (ny_den),
      .in_side   (ny_side),
      .out_valid (yq_valid),
      .out_quo   (yq_quo),
      .out_ovf   (yq_ovf),
      .out_side  (yq_side)
   );

   // ------------------------------------------------------------------------
   // middle: clamp y, x numerator 2 y dy01 - t2 2^F
   // ------------------------------------------------------------------------
   logic                    v8_ff, v9_ff, v10_ff, v11_ff;
   logic signed [OUT_W-1:0] py8_ff, py9_ff, py10_ff, py11_ff;
   logic                    cy8_ff, cy9_ff, cy10_ff, cy11_ff;
   logic signed [TW-1:0]    t2_8_ff, t2_9_ff;
   logic signed [QW-1:0]    prod_ff;
   logic signed [NXW-1:0]   nx_ff;
   logic [NXW-1:0]          nxmag_ff;
   logic                    nxneg_ff;

   sat_type                 ysat;
   logic signed [NXW-1:0]   pe, te, nx_in;

   assign ysat  = saturate(yq_side[SYW-1], yq_quo, yq_ovf);
   assign pe    = NXW'(prod_ff);
   assign te    = NXW'(t2_9_ff);
   assign nx_in = (pe <<< 1) - (te <<< F);

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (adv) begin
         v8_ff  <= yq_valid;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         py8_ff   <= ysat.val;
         cy8_ff   <= ysat.clip;
         t2_8_ff  <= yq_side[TW-1:0];
         prod_ff  <= py8_ff * dy01_ff;
         py9_ff   <= py8_ff;
         cy9_ff   <= cy8_ff;
         t2_9_ff  <= t2_8_ff;
         nx_ff    <= nx_in;
         py10_ff  <= py9_ff;
         cy10_ff  <= cy9_ff;
         nxneg_ff <= nx_ff[NXW-1];
         nxmag_ff <= nx_ff[NXW-1] ? NXW'(-nx_ff) : NXW'(nx_ff);
         py11_ff  <= py10_ff;
         cy11_ff  <= cy10_ff;
      end
   end

   // ------------------------------------------------------------------------
   // x divider: round(nx / (2 dx10)) as (2|nx| + 2|dx10|) / (4|dx10|)
   // ------------------------------------------------------------------------
   logic [NX2W-1:0] nx2_num, nx2_den;
   logic [SXW-1:0]  nx_side, xq_side;
   logic            xq_valid, xq_ovf;
   logic [OUT_W-1:0] xq_quo;

   assign nx2_num = (NX2W'(nxmag_ff) << 1) + (NX2W'(dxmag_ff) << 1);
   assign nx2_den = NX2W'(dxmag_ff) << 2;
   assign nx_side = {nxneg_ff ^ dxneg_ff, py11_ff, cy11_ff};

   tat_div #(
      .NW (NX2W),
      .QB (OUT_W),
      .SW (SXW)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v11_ff),
      .in_num    (nx2_num),
      .in_den    (nx2_den),
      .in_side   (nx_side),
      .out_valid (xq_valid),
      .out_quo   (xq_quo),
      .out_ovf   (xq_ovf),
      .out_side  (xq_side)
   );

   // ------------------------------------------------------------------------
   // output register: clamp x, apply the degenerate cases
   // ------------------------------------------------------------------------
   sat_type                 xsat;
   logic signed [OUT_W-1:0] px_in, py_in;
   status_type              status_in;
   logic                    clip_in;

   assign xsat = saturate(xq_side[SXW-1], xq_quo, xq_ovf);

   always_comb begin
      if (det_zero) begin
         // collinear anchors: nothing to report
         status_in = ST_COLLINEAR;
         px_in     = '0;
         py_in     = '0;
         clip_in   = 1'b0;
      end else if (dx_zero) begin
         // anchors 0 and 1 share x: y only
         status_in = ST_SHARED_X;
         px_in     = '0;
         py_in     = xq_side[OUT_W:1];
         clip_in   = xq_side[0];
      end else begin
         status_in = ST_OK;
         px_in     = xsat.val;
         py_in     = xq_side[OUT_W:1];
         clip_in   = xq_side[0] | xsat.clip;
      end
   end

   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= xq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pos_x   <= px_in;
         rsp_pos_y   <= py_in;
         rsp_status  <= status_in;
         rsp_clipped <= clip_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/tat_div.sv
// ----------------------------------------------------------------------------
// tat_div
// pipelined restoring divider, one quotient bit per stage, overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module tat_div #(
   parameter int NW = 64,
   parameter int QB = 26,
   parameter int SW = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [NW-1:0] in_num,
   input  wire logic [NW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [QB-1:0]      out_quo,
   output logic               out_ovf,
   output logic [SW-1:0]      out_side
);

   localparam int XW = NW + QB;

   logic          v_ff    [QB+1];
   logic [XW-1:0] rem_ff  [QB+1];
   logic [XW-1:0] den_ff  [QB+1];
   logic [QB-1:0] quo_ff  [QB+1];
   logic          ovf_ff  [QB+1];
   logic [SW-1:0] side_ff [QB+1];

   logic [XW-1:0] num_x;
   logic [XW-1:0] den_x;

   assign num_x = XW'(in_num);
   assign den_x = XW'(in_den);

   // entry stage: quotient too large for QB bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= num_x;
         den_ff[0]  <= den_x;
         quo_ff[0]  <= '0;
         ovf_ff[0]  <= num_x >= (den_x << QB);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= QB; k++) begin : g_stage
      localparam int SH = QB - k;
      logic [XW-1:0] dsh;
      logic [XW:0]   diff;
      logic          take;
      logic [QB-1:0] quo_in;

      assign dsh  = den_ff[k-1] << SH;
      assign diff = {1'b0, rem_ff[k-1]} - {1'b0, dsh};
      assign take = !diff[XW];

      always_comb begin
         quo_in     = quo_ff[k-1];
         quo_in[SH] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= take ? diff[XW-1:0] : rem_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= quo_in;
            ovf_ff[k]  <= ovf_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_quo   = quo_ff[QB];
   assign out_ovf   = ovf_ff[QB];
   assign out_side  = side_ff[QB];

endmodule

`default_nettype wire
